// File: design/assert_macros.svh
// Assertion macros shared by the RTL files.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

// File: design/thpc_pkg.sv
// Types and constants of the sensor compensation block.
// No dependencies.
`default_nettype none

package thpc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TEMPERATURE   = 3'd0;
  localparam logic [2:0] REG_PRESSURE_LOW  = 3'd1;
  localparam logic [2:0] REG_PRESSURE_HIGH = 3'd2;
  localparam logic [2:0] REG_MIXED         = 3'd3;
  localparam logic [2:0] REG_HUMIDITY      = 3'd4;

  localparam logic signed [31:0] HUMIDITY_MAX = 32'sd419430400;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } thpc_sample_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
    logic               pressure_invalid;
  } thpc_result_t;

endpackage

`default_nettype wire

// File: design/thp_sensor_compensation.sv
// Throughput: one item per cycle; busy is always low and results are never held.
// The 64-step restoring divider for pressure sets the depth (one quotient bit a stage).
// Reset (rst, synchronous) clears all stage valid bits and the coefficient registers.
// Configuration writes are taken in any cycle; cfg_ready is always high.
// Top level of the sensor compensation pipeline; uses thpc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module thp_sensor_compensation (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire thpc_pkg::thpc_sample_t sample,
  output logic                       done,
  output thpc_pkg::thpc_result_t     result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [63:0]           cfg_data
);

  localparam int DivSteps = 64;

  typedef struct packed {
    logic signed [31:0] temp;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic               inval;
    logic               sgn;
  } side_t;

  // Coefficient registers
  logic [47:0] cfg_t;
  logic [63:0] cfg_pl;
  logic [63:0] cfg_ph;
  logic [47:0] cfg_mix;
  logic [31:0] cfg_h;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_t   <= '0;
      cfg_pl  <= '0;
      cfg_ph  <= '0;
      cfg_mix <= '0;
      cfg_h   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        thpc_pkg::REG_TEMPERATURE:   cfg_t   <= cfg_data[47:0];
        thpc_pkg::REG_PRESSURE_LOW:  cfg_pl  <= cfg_data;
        thpc_pkg::REG_PRESSURE_HIGH: cfg_ph  <= cfg_data;
        thpc_pkg::REG_MIXED:         cfg_mix <= cfg_data[47:0];
        thpc_pkg::REG_HUMIDITY:      cfg_h   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Unpack coefficients
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic [7:0]         h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = cfg_t[15:0];
  assign t2 = cfg_t[31:16];
  assign t3 = cfg_t[47:32];
  assign p1 = cfg_pl[15:0];
  assign p2 = cfg_pl[31:16];
  assign p3 = cfg_pl[47:32];
  assign p4 = cfg_pl[63:48];
  assign p5 = cfg_ph[15:0];
  assign p6 = cfg_ph[31:16];
  assign p7 = cfg_ph[47:32];
  assign p8 = cfg_ph[63:48];
  assign p9 = cfg_mix[15:0];
  assign h1 = cfg_mix[23:16];
  assign h2 = cfg_mix[39:24];
  assign h3 = cfg_mix[47:40];
  assign h4 = cfg_h[11:0];
  assign h5 = cfg_h[23:12];
  assign h6 = cfg_h[31:24];

  // Stage valid bits
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;
  logic vd1, vd2, vd3, vd4, vd5;
  logic dv_valid [0:DivSteps];

  // ---------------- stage 1: temperature differences ----------------
  logic signed [17:0] s1_x1, s1_dd, x1_next, dd_next;
  logic [19:0]        s1_praw;
  logic [15:0]        s1_hraw;

  assign x1_next = {1'b0, sample.raw_temperature[19:3]} - {1'b0, t1, 1'b0};
  assign dd_next = {2'b00, sample.raw_temperature[19:4]} - {2'b00, t1};

  always_ff @(posedge clk) begin
    s1_x1   <= x1_next;
    s1_dd   <= dd_next;
    s1_praw <= sample.raw_pressure;
    s1_hraw <= sample.raw_humidity;
  end

  // ---------------- stage 2: temperature products ----------------
  logic signed [33:0] ma_next;
  logic signed [35:0] dsq_next;
  logic signed [31:0] s2_ma, s2_dsq;
  logic [19:0]        s2_praw;
  logic [15:0]        s2_hraw;

  assign ma_next  = s1_x1 * t2;
  assign dsq_next = s1_dd * s1_dd;

  always_ff @(posedge clk) begin
    s2_ma   <= ma_next[31:0];
    s2_dsq  <= dsq_next[31:0];
    s2_praw <= s1_praw;
    s2_hraw <= s1_hraw;
  end

  // ---------------- stage 3: scale by T3 ----------------
  logic signed [31:0] dsq_sh, s3_a32, s3_mb;
  logic signed [47:0] mb_next;
  logic [19:0]        s3_praw;
  logic [15:0]        s3_hraw;

  assign dsq_sh  = s2_dsq >>> 12;
  assign mb_next = dsq_sh * t3;

  always_ff @(posedge clk) begin
    s3_a32  <= s2_ma >>> 11;
    s3_mb   <= mb_next[31:0];
    s3_praw <= s2_praw;
    s3_hraw <= s2_hraw;
  end

  // ---------------- stage 4: fine temperature ----------------
  logic signed [31:0] s4_fine;
  logic [19:0]        s4_praw;
  logic [15:0]        s4_hraw;

  always_ff @(posedge clk) begin
    s4_fine <= s3_a32 + (s3_mb >>> 14);
    s4_praw <= s3_praw;
    s4_hraw <= s3_hraw;
  end

  // ---------------- stage 5: temperature, offsets ----------------
  logic signed [31:0] t5_next, s5_temp, s5_hv;
  logic signed [33:0] s5_pa;
  logic [19:0]        s5_praw;
  logic [15:0]        s5_hraw;

  assign t5_next = s4_fine * 32'sd5 + 32'sd128;

  always_ff @(posedge clk) begin
    s5_temp <= t5_next >>> 8;
    s5_pa   <= 34'(s4_fine) - 34'sd128000;
    s5_hv   <= s4_fine - 32'sd76800;
    s5_praw <= s4_praw;
    s5_hraw <= s4_hraw;
  end

  // ---------------- stage 6: square of offset, humidity products ----------------
  logic signed [67:0] asq_next;
  logic signed [43:0] h5hv_next;
  logic signed [39:0] hvh6_next;
  logic signed [40:0] hvh3_next;
  logic signed [31:0] s6_temp, s6_h5hv, s6_hvh6, s6_hvh3;
  logic signed [33:0] s6_pa;
  logic signed [63:0] s6_asq;
  logic [19:0]        s6_praw;
  logic [15:0]        s6_hraw;

  assign asq_next  = s5_pa * s5_pa;
  assign h5hv_next = h5 * s5_hv;
  assign hvh6_next = s5_hv * h6;
  assign hvh3_next = s5_hv * $signed({1'b0, h3});

  always_ff @(posedge clk) begin
    s6_temp <= s5_temp;
    s6_pa   <= s5_pa;
    s6_asq  <= asq_next[63:0];
    s6_h5hv <= h5hv_next[31:0];
    s6_hvh6 <= hvh6_next[31:0];
    s6_hvh3 <= hvh3_next[31:0];
    s6_praw <= s5_praw;
    s6_hraw <= s5_hraw;
  end

  // ---------------- stage 7: P6 and P5 terms, humidity base ----------------
  logic signed [79:0] b1_next;
  logic signed [49:0] ap5_next, s7_ap5;
  logic signed [31:0] hxa_next, s7_temp, s7_hx, s7_u, s7_w;
  logic signed [33:0] s7_pa;
  logic signed [63:0] s7_asq, s7_b1;
  logic [19:0]        s7_praw;

  assign b1_next  = s6_asq * p6;
  assign ap5_next = s6_pa * p5;
  assign hxa_next = $signed({2'b00, s6_hraw, 14'd0}) - $signed({h4, 20'd0})
                  - s6_h5hv + 32'sd16384;

  always_ff @(posedge clk) begin
    s7_temp <= s6_temp;
    s7_pa   <= s6_pa;
    s7_asq  <= s6_asq;
    s7_b1   <= b1_next[63:0];
    s7_ap5  <= ap5_next;
    s7_hx   <= hxa_next >>> 15;
    s7_u    <= s6_hvh6 >>> 10;
    s7_w    <= (s6_hvh3 >>> 11) + 32'sd32768;
    s7_praw <= s6_praw;
  end

  // ---------------- stage 8: subtrahend sum, P3 and P2 terms ----------------
  logic signed [63:0] b_next, uw_next, s8_b, s8_asq3;
  logic signed [79:0] asq3_next;
  logic signed [49:0] ap2_next, s8_ap2;
  logic signed [31:0] s8_temp, s8_hx, s8_uw;
  logic [19:0]        s8_praw;

  assign b_next    = s7_b1 + (64'(s7_ap5) <<< 17) + (64'(p4) <<< 35);
  assign asq3_next = s7_asq * p3;
  assign ap2_next  = s7_pa * p2;
  assign uw_next   = s7_u * s7_w;

  always_ff @(posedge clk) begin
    s8_temp <= s7_temp;
    s8_b    <= b_next;
    s8_asq3 <= asq3_next[63:0];
    s8_ap2  <= ap2_next;
    s8_hx   <= s7_hx;
    s8_uw   <= uw_next[31:0];
    s8_praw <= s7_praw;
  end

  // ---------------- stage 9: divisor sum, dividend base ----------------
  logic [20:0]        pd;
  logic signed [63:0] s9_a2, s9_n0;
  logic signed [31:0] s9_temp, s9_hx, s9_hy0;

  assign pd = 21'd1048576 - {1'b0, s8_praw};

  always_ff @(posedge clk) begin
    s9_temp <= s8_temp;
    s9_a2   <= (s8_asq3 >>> 8) + (64'(s8_ap2) <<< 12);
    s9_n0   <= $signed({12'd0, pd, 31'd0}) - s8_b;
    s9_hx   <= s8_hx;
    s9_hy0  <= (s8_uw >>> 10) + 32'sd2097152;
  end

  // ---------------- stage 10: scale divisor by P1, dividend by 3125 ----------------
  logic signed [63:0] a2p, n_next, s10_a3p, s10_n;
  logic signed [80:0] a3p_next;
  logic signed [47:0] hyp_next;
  logic signed [31:0] s10_temp, s10_hx, s10_hyh;

  assign a2p      = s9_a2 + 64'sh0000_8000_0000_0000;
  assign a3p_next = a2p * $signed({1'b0, p1});
  assign n_next   = s9_n0 * 64'sd3125;
  assign hyp_next = s9_hy0 * h2;

  always_ff @(posedge clk) begin
    s10_temp <= s9_temp;
    s10_a3p  <= a3p_next[63:0];
    s10_n    <= n_next;
    s10_hx   <= s9_hx;
    s10_hyh  <= $signed(hyp_next[31:0]) + 32'sd8192;
  end

  // ---------------- stage 11: divider entry (magnitudes and sign) ----------------
  logic signed [63:0] a3_next;
  logic [63:0]        dv_rem  [0:DivSteps];
  logic [63:0]        dv_num  [0:DivSteps];
  logic [63:0]        dv_md   [0:DivSteps];
  side_t              dv_side [0:DivSteps];

  assign a3_next = s10_a3p >>> 33;

  always_ff @(posedge clk) begin
    dv_rem[0]        <= '0;
    dv_num[0]        <= s10_n[63] ? 64'(-s10_n) : s10_n;
    dv_md[0]         <= a3_next[63] ? 64'(-a3_next) : a3_next;
    dv_side[0].temp  <= s10_temp;
    dv_side[0].hx    <= s10_hx;
    dv_side[0].hy    <= s10_hyh >>> 14;
    dv_side[0].inval <= (a3_next == 64'sd0);
    dv_side[0].sgn   <= s10_n[63] ^ a3_next[63];
  end

  // ---------------- restoring divider, one quotient bit a stage ----------------
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [64:0] shifted;
    logic [64:0] diff;
    logic        ge;

    assign shifted = {dv_rem[k], dv_num[k][63]};
    assign diff    = shifted - {1'b0, dv_md[k]};
    assign ge      = (shifted >= {1'b0, dv_md[k]});

    always_ff @(posedge clk) begin
      dv_rem[k+1]  <= ge ? diff[63:0] : shifted[63:0];
      dv_num[k+1]  <= {dv_num[k][62:0], ge};
      dv_md[k+1]   <= dv_md[k];
      dv_side[k+1] <= dv_side[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end
  end

  // ---------------- post 1: signed quotient, humidity product ----------------
  side_t              d1_side;
  logic signed [63:0] d1_q, d1_s, q_next, hv2_next;

  assign q_next   = dv_side[DivSteps].sgn ? 64'(-dv_num[DivSteps]) : dv_num[DivSteps];
  assign hv2_next = dv_side[DivSteps].hx * dv_side[DivSteps].hy;

  logic signed [31:0] d1_hv2;

  always_ff @(posedge clk) begin
    d1_side <= dv_side[DivSteps];
    d1_q    <= q_next;
    d1_s    <= q_next >>> 13;
    d1_hv2  <= hv2_next[31:0];
  end

  // ---------------- post 2: low square half, P8 term ----------------
  logic [63:0]        m0_next, d2_m0;
  logic signed [79:0] dp_next;
  logic signed [16:0] r_next;
  logic signed [33:0] sq_next;
  logic signed [31:0] hv2_sh, d2_hv2, d2_sq;
  logic signed [63:0] d2_q, d2_s, d2_dp;
  side_t              d2_side;

  assign m0_next = d1_s[31:0] * d1_s[31:0];
  assign dp_next = d1_q * p8;
  assign hv2_sh  = d1_hv2 >>> 15;
  assign r_next  = hv2_sh[16:0];
  assign sq_next = r_next * r_next;

  always_ff @(posedge clk) begin
    d2_side <= d1_side;
    d2_q    <= d1_q;
    d2_s    <= d1_s;
    d2_m0   <= m0_next;
    d2_dp   <= dp_next[63:0];
    d2_hv2  <= d1_hv2;
    d2_sq   <= sq_next[31:0];
  end

  // ---------------- post 3: cross square half, H1 term ----------------
  logic [63:0]        m1_next;
  logic signed [31:0] sq_sh, d3_hv2, d3_tt;
  logic signed [40:0] tt_next;
  logic signed [63:0] d3_q, d3_dp, d3_sqs;
  side_t              d3_side;

  assign m1_next = d2_s[63:32] * d2_s[31:0];
  assign sq_sh   = d2_sq >>> 7;
  assign tt_next = sq_sh * $signed({1'b0, h1});

  always_ff @(posedge clk) begin
    d3_side <= d2_side;
    d3_q    <= d2_q;
    d3_dp   <= d2_dp;
    d3_sqs  <= d2_m0 + {m1_next[30:0], 33'd0};
    d3_hv2  <= d2_hv2;
    d3_tt   <= tt_next[31:0];
  end

  // ---------------- post 4: P9 term, humidity clamp ----------------
  logic signed [79:0] c0_next;
  logic signed [31:0] hv3_next, hcl_next;
  logic signed [63:0] d4_q, d4_dp, d4_c0;
  logic [16:0]        d4_hum;
  side_t              d4_side;

  assign c0_next  = d3_sqs * p9;
  assign hv3_next = d3_hv2 - (d3_tt >>> 4);

  // Clamp humidity to zero..full scale
  always_comb begin
    priority if (hv3_next[31]) begin
      hcl_next = '0;
    end else if (hv3_next > thpc_pkg::HUMIDITY_MAX) begin
      hcl_next = thpc_pkg::HUMIDITY_MAX;
    end else begin
      hcl_next = hv3_next;
    end
  end

  always_ff @(posedge clk) begin
    d4_side <= d3_side;
    d4_q    <= d3_q;
    d4_dp   <= d3_dp;
    d4_c0   <= c0_next[63:0];
    d4_hum  <= hcl_next[28:12];
  end

  // ---------------- post 5: pressure sum ----------------
  logic signed [63:0] d5_sum;
  logic [16:0]        d5_hum;
  side_t              d5_side;

  always_ff @(posedge clk) begin
    d5_side <= d4_side;
    d5_sum  <= d4_q + (d4_c0 >>> 25) + (d4_dp >>> 19);
    d5_hum  <= d4_hum;
  end

  // ---------------- post 6: final pressure, saturate, result register ----------------
  logic signed [63:0] pf_next;
  logic [31:0]        pres_next;

  assign pf_next = (d5_sum >>> 8) + (64'(p7) <<< 4);

  always_comb begin
    priority if (d5_side.inval || pf_next[63]) begin
      pres_next = '0;
    end else if (pf_next[63:32] != 32'd0) begin
      pres_next = '1;
    end else begin
      pres_next = pf_next[31:0];
    end
  end

  always_ff @(posedge clk) begin
    result.temperature_centi <= d5_side.temp;
    result.pressure_q24_8    <= pres_next;
    result.humidity_q22_10   <= d5_hum;
    result.pressure_invalid  <= d5_side.inval;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0;
      dv_valid[0] <= 1'b0;
      vd1 <= 1'b0; vd2 <= 1'b0; vd3 <= 1'b0; vd4 <= 1'b0; vd5 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8; v10 <= v9;
      dv_valid[0] <= v10;
      vd1 <= dv_valid[DivSteps];
      vd2 <= vd1; vd3 <= vd2; vd4 <= vd3; vd5 <= vd4;
      done <= vd5;
    end
  end

  // ---------------- checks ----------------
  `ASSERT_IMPLIES(a_invalid_zero, clk, rst, done && result.pressure_invalid, result.pressure_q24_8 == 32'd0)
  `ASSERT_IMPLIES(a_humidity_range, clk, rst, done, result.humidity_q22_10 <= 17'd102400)
  `ASSERT_IMPLIES(a_div_flag, clk, rst, dv_valid[0], dv_side[0].inval == (dv_md[0] == 64'd0))
  `ASSERT_NEXT(a_tail_flow, clk, rst, vd5, done)

endmodule

`default_nettype wire

// File: test/tb_thp_sensor_compensation.sv
// Self-checking testbench for the sensor compensation pipeline.
// Directed rows are checked against fixed or predicted results, random samples against an in-bench predictor of
// the integer compensation; depends on thpc_pkg and thp_sensor_compensation.
`timescale 1ns / 100ps

module tb_thp_sensor_compensation;

  localparam int LATENCY = 80;
  localparam int N_RANDOM = 900;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  thpc_pkg::thpc_sample_t sample = '0;
  logic done;
  thpc_pkg::thpc_result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = thpc_pkg::REG_TEMPERATURE;
  logic [63:0] cfg_data = '0;

  // Coefficient copies held by the predictor
  logic [63:0] coef [0:4];
  thpc_pkg::thpc_result_t pending_results [$];
  int mismatches = 0;

  typedef struct {
    thpc_pkg::thpc_sample_t smp;
    logic has_exp;
    thpc_pkg::thpc_result_t exp;
  } stim_row_t;
  stim_row_t directed [$];

  always #2 clk = ~clk;

  thp_sensor_compensation DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic logic signed [63:0] sx64(logic [63:0] v, int pos, int bits);
    logic [63:0] x;
    x = (v >> pos) & ((64'd1 << bits) - 1);
    if (x[bits-1]) x = x | ~((64'd1 << bits) - 1);
    return $signed(x);
  endfunction

  // Compensate one raw sample triple with the current coefficients
  function automatic thpc_pkg::thpc_result_t compensate(thpc_pkg::thpc_sample_t s);
    logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] a32, b32, d32, fine, hv, hx, hy;
    logic signed [63:0] a, b, c, d, p, num, an, dn;
    logic [63:0] q;
    thpc_pkg::thpc_result_t r;
    t1 = 32'(coef[0][15:0]);
    t2 = 32'(sx64(coef[0], 16, 16));
    t3 = 32'(sx64(coef[0], 32, 16));
    p1 = 64'(coef[1][15:0]);
    p2 = sx64(coef[1], 16, 16);
    p3 = sx64(coef[1], 32, 16);
    p4 = sx64(coef[1], 48, 16);
    p5 = sx64(coef[2], 0, 16);
    p6 = sx64(coef[2], 16, 16);
    p7 = sx64(coef[2], 32, 16);
    p8 = sx64(coef[2], 48, 16);
    p9 = sx64(coef[3], 0, 16);
    h1 = 32'(coef[3][23:16]);
    h2 = 32'(sx64(coef[3], 24, 16));
    h3 = 32'(coef[3][47:40]);
    h4 = 32'(sx64(coef[4], 0, 12));
    h5 = 32'(sx64(coef[4], 12, 12));
    h6 = 32'(sx64(coef[4], 24, 8));
    r = '0;
    // temperature
    a32 = ((($signed({12'd0, s.raw_temperature}) >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d32 = ($signed({12'd0, s.raw_temperature}) >>> 4) - t1;
    b32 = (((d32 * d32) >>> 12) * t3) >>> 14;
    fine = a32 + b32;
    r.temperature_centi = (fine * 5 + 128) >>> 8;
    // pressure
    a = 64'(fine) - 64'sd128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    if (a == 0) begin
      r.pressure_invalid = 1'b1;
    end else begin
      p = 64'sd1048576 - $signed({44'd0, s.raw_pressure});
      num = ((p <<< 31) - b) * 64'sd3125;
      an = num[63] ? -num : num;
      dn = a[63] ? -a : a;
      q = $unsigned(an) / $unsigned(dn);
      p = (num[63] != a[63]) ? -$signed(q) : $signed(q);
      c = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      d = (p8 * p) >>> 19;
      p = ((p + c + d) >>> 8) + (p7 <<< 4);
      if (p < 0) r.pressure_q24_8 = '0;
      else if (p > 64'sd4294967295) r.pressure_q24_8 = '1;
      else r.pressure_q24_8 = p[31:0];
    end
    // humidity
    hv = fine - 32'sd76800;
    hx = (($signed({16'd0, s.raw_humidity}) <<< 14) - (h4 <<< 20) - h5 * hv + 16384) >>> 15;
    hy = ((((hv * h6) >>> 10) * (((hv * h3) >>> 11) + 32768)) >>> 10) + 32'sd2097152;
    hy = (hy * h2 + 8192) >>> 14;
    hv = hx * hy;
    hv = hv - (((((hv >>> 15) * (hv >>> 15)) >>> 7) * h1) >>> 4);
    if (hv < 0) hv = 0;
    else if (hv > thpc_pkg::HUMIDITY_MAX) hv = thpc_pkg::HUMIDITY_MAX;
    r.humidity_q22_10 = 17'(hv >>> 12);
    return r;
  endfunction

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    thpc_pkg::thpc_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        e = pending_results.pop_front();
        if (result.temperature_centi !== e.temperature_centi ||
            result.pressure_q24_8 !== e.pressure_q24_8 ||
            result.humidity_q22_10 !== e.humidity_q22_10 ||
            result.pressure_invalid !== e.pressure_invalid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp t=%0d p=%h h=%0d inv=%b got t=%0d p=%h h=%0d inv=%b",
                     e.temperature_centi, e.pressure_q24_8, e.humidity_q22_10,
                     e.pressure_invalid, result.temperature_centi, result.pressure_q24_8,
                     result.humidity_q22_10, result.pressure_invalid);
        end
      end
    end
  end

  task automatic idle_burst(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Present one item and hold until accepted
  task automatic send_sample(thpc_pkg::thpc_sample_t s, bit allow_idle, bit typed,
                             thpc_pkg::thpc_result_t exp);
    // Release the configuration channel
    cfg_valid <= 1'b0;
    idle_burst(allow_idle);
    start <= 1'b1;
    sample <= s;
    do @(posedge clk); while (busy);
    pending_results.push_back(typed ? exp : compensate(s));
  endtask

  task automatic write_coef(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      thpc_pkg::REG_TEMPERATURE, thpc_pkg::REG_MIXED: coef[idx] = val & 64'hFFFF_FFFF_FFFF;
      thpc_pkg::REG_HUMIDITY: coef[idx] = val & 64'hFFFF_FFFF;
      default: coef[idx] = val;
    endcase
  endtask

  // Drain the pipeline before touching coefficients
  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_typical;
    write_coef(thpc_pkg::REG_TEMPERATURE, 64'({16'sd50, 16'sd26435, 16'd27504}));
    write_coef(thpc_pkg::REG_PRESSURE_LOW, {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477});
    write_coef(thpc_pkg::REG_PRESSURE_HIGH, {-16'sd2068, -16'sd7, 16'sd15500, 16'sd140});
    write_coef(thpc_pkg::REG_MIXED, 64'({8'd0, 16'sd361, 8'd75, 16'sd6000}));
    write_coef(thpc_pkg::REG_HUMIDITY, 64'({8'sd30, 12'sd50, 12'sd313}));
  endtask

  function automatic thpc_pkg::thpc_sample_t rand_sample;
    thpc_pkg::thpc_sample_t s;
    s.raw_temperature = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(400000, 600000));
    s.raw_pressure = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(250000, 450000));
    s.raw_humidity = 16'($urandom);
    return s;
  endfunction

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    thpc_pkg::thpc_result_t zero_res;
    thpc_pkg::thpc_sample_t s;
    for (int i = 0; i < 5; i++) coef[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With all coefficients zero the pressure divisor is zero
    zero_res = '0;
    zero_res.pressure_invalid = 1'b1;
    directed.push_back('{'{20'd0, 20'd0, 16'd0}, 1'b1, zero_res});
    directed.push_back('{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, 1'b1, zero_res});
    foreach (directed[i])
      send_sample(directed[i].smp, 1'b0, directed[i].has_exp, directed[i].exp);
    directed.delete();
    drain();

    // Typical calibration: extremes of every field, mid-range values and alternating bit patterns
    load_typical();
    directed.push_back('{'{20'd0, 20'd0, 16'd0}, 1'b0, '0});
    directed.push_back('{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, 1'b0, '0});
    directed.push_back('{'{20'd519888, 20'd415148, 16'd30000}, 1'b0, '0});
    directed.push_back('{'{20'd519888, 20'd0, 16'hFFFF}, 1'b0, '0});
    directed.push_back('{'{20'd519888, 20'hFFFFF, 16'd0}, 1'b0, '0});
    directed.push_back('{'{20'hAAAAA, 20'h55555, 16'hAAAA}, 1'b0, '0});
    directed.push_back('{'{20'h55555, 20'hAAAAA, 16'h5555}, 1'b0, '0});
    foreach (directed[i])
      send_sample(directed[i].smp, 1'b1, directed[i].has_exp, directed[i].exp);
    drain();

    // Extreme coefficients: saturation and humidity clamps
    write_coef(thpc_pkg::REG_TEMPERATURE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_coef(thpc_pkg::REG_PRESSURE_LOW, 64'h7FFF_8000_7FFF_FFFF);
    write_coef(thpc_pkg::REG_PRESSURE_HIGH, 64'h8000_7FFF_8000_7FFF);
    write_coef(thpc_pkg::REG_MIXED, 64'h0000_FF7F_FFFF_8000);
    write_coef(thpc_pkg::REG_HUMIDITY, 64'h0000_0000_8080_0800);
    foreach (directed[i])
      send_sample(directed[i].smp, 1'b1, directed[i].has_exp, directed[i].exp);
    drain();

    // Random phases with typical, fully random and partly random calibrations
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) load_typical();
      else if (ph < 5)
        for (int r = 0; r < 5; r++)
          write_coef(3'(r), {$urandom, $urandom});
      else begin
        load_typical();
        write_coef(thpc_pkg::REG_PRESSURE_LOW, {$urandom, 16'($urandom), 16'd0});
      end
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        s = rand_sample();
        send_sample(s, ph < 5, 1'b0, zero_res);
      end
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
